// ===== hdl/csr_pkg.sv =====
// Shared types and constants of the clipped shape span rasterizer.
// No dependencies; imported by every module of the block.
package csr_pkg;

  localparam int COORD_BITS    = 10;
  localparam int MAX_RADIUS    = 31;
  localparam int MAX_RECT_ROWS = 64;
  localparam int SCREEN_MAX    = 256;

  localparam int CLIP_BITS     = 9;
  localparam int ROW_BITS      = 10;
  localparam int EXT_BITS      = 12;
  localparam int RADIUS_BITS   = 5;
  localparam int HEIGHT_BITS   = 7;
  localparam int WIDTH_BITS    = 9;
  localparam int COLOR_BITS    = 15;
  localparam int PIX_BITS      = 16;
  localparam int SPAN_BITS     = 8;
  localparam int SQ_BITS       = 2 * RADIUS_BITS;
  localparam int STEP_BITS     = 3;

  localparam int IN_DATA_BITS  = 56;
  localparam int OUT_DATA_BITS = 40;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_HEIGHT = 1'b1;

  localparam logic FUNC_CIRCLE = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic root_start;
    logic emit_span;
    logic emit_none;
  } csr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_circle;
    logic no_rows;
    logic last_row;
    logic out_free;
    logic root_done;
  } csr_status_t;

endpackage

// ===== hdl/csr_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on csr_pkg.
module csr_isqrt import csr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SQ_BITS-1:0]     operand_i,
  output logic [RADIUS_BITS-1:0] root_o,
  output logic                   done_o
);

  logic                   busy_q;
  logic [STEP_BITS-1:0]   step_q;
  logic [SQ_BITS-1:0]     val_q;
  logic [RADIUS_BITS-1:0] res_q, res_d;
  logic [RADIUS_BITS-1:0] trial;
  logic [SQ_BITS-1:0]     trial_sq;

  assign trial    = res_q | (RADIUS_BITS'(1) << step_q);
  assign trial_sq = SQ_BITS'(trial) * SQ_BITS'(trial);
  assign res_d    = (trial_sq <= val_q) ? trial : res_q;

  // The final bit resolves at the edge that ends this cycle.
  assign done_o = busy_q && (step_q == '0);
  assign root_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_BITS'(RADIUS_BITS - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q - STEP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= operand_i;
      res_q <= '0;
    end else if (busy_q) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== hdl/csr_dp.sv =====
// Datapath: held command, row bounds, per-row span math and output register.
// Depends on csr_pkg and csr_isqrt.
module csr_dp import csr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  csr_cmd_t                 cmd_i,
  output csr_status_t              status_o,
  input  logic [CLIP_BITS-1:0]     clip_w_i,
  input  logic [CLIP_BITS-1:0]     clip_h_i,
  input  logic [IN_DATA_BITS-1:0]  in_data_i,
  input  logic                     in_func_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [OUT_DATA_BITS-1:0] out_data_o,
  output logic                     out_empty_o,
  output logic                     out_last_o
);

  localparam logic signed [EXT_BITS-1:0] ZERO_E = '0;
  localparam logic signed [EXT_BITS-1:0] ONE_E  = EXT_BITS'(1);

  localparam int PY_LSB = COORD_BITS;
  localparam int W_LSB  = 2 * COORD_BITS;
  localparam int H_LSB  = W_LSB + WIDTH_BITS;
  localparam int R_LSB  = H_LSB + HEIGHT_BITS;
  localparam int C_LSB  = R_LSB + RADIUS_BITS;

  // Held command
  logic                         func_q;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [WIDTH_BITS-1:0]        w_q;
  logic [HEIGHT_BITS-1:0]       h_q;
  logic [RADIUS_BITS-1:0]       r_q;
  logic [COLOR_BITS-1:0]        color_q;

  // Bounds and row walker
  logic [ROW_BITS-1:0]          row_q, row_d;
  logic [CLIP_BITS-1:0]         yhi_q, yhi_d;
  logic signed [EXT_BITS-1:0]   xl_q, xr_q, xl_d, xr_d;
  logic [SQ_BITS-1:0]           rsq_q, rsq_d;

  // Output register
  logic                         out_valid_q;
  logic [SPAN_BITS-1:0]         out_row_q, out_start_q, out_end_q;
  logic [PIX_BITS-1:0]          out_pix_q;
  logic                         out_empty_q, out_last_q;

  logic                         is_circle, out_free;
  logic signed [EXT_BITS-1:0]   px_e, py_e, w_e, h_e, r_e, wclip_e, hclip_e;
  logic [HEIGHT_BITS-1:0]       h_sat;
  logic [RADIUS_BITS-1:0]       r_sat;
  logic signed [EXT_BITS-1:0]   top_raw, bot_raw, bot_min, ylo, yhi, rect_r;
  logic signed [EXT_BITS-1:0]   row_e, dy, ady;
  logic [RADIUS_BITS-1:0]       ady_n;
  logic [SQ_BITS-1:0]           rem_sq;
  logic [RADIUS_BITS-1:0]       root;
  logic                         root_done;
  logic signed [EXT_BITS-1:0]   dx_e, cxl, cxr, cxl_c, cxr_c, span_l, span_r;
  logic                         span_empty;

  assign is_circle = (func_q == FUNC_CIRCLE);
  assign out_free  = !out_valid_q || out_ready_i;

  // Sign or zero extend everything into one common signed width.
  assign px_e    = {{(EXT_BITS-COORD_BITS){px_q[COORD_BITS-1]}}, px_q};
  assign py_e    = {{(EXT_BITS-COORD_BITS){py_q[COORD_BITS-1]}}, py_q};
  assign h_sat   = (h_q > HEIGHT_BITS'(MAX_RECT_ROWS)) ? HEIGHT_BITS'(MAX_RECT_ROWS) : h_q;
  assign r_sat   = (r_q > RADIUS_BITS'(MAX_RADIUS)) ? RADIUS_BITS'(MAX_RADIUS) : r_q;
  assign w_e     = $signed({{(EXT_BITS-WIDTH_BITS){1'b0}}, w_q});
  assign h_e     = $signed({{(EXT_BITS-HEIGHT_BITS){1'b0}}, h_sat});
  assign r_e     = $signed({{(EXT_BITS-RADIUS_BITS){1'b0}}, r_sat});
  assign wclip_e = $signed({{(EXT_BITS-CLIP_BITS){1'b0}}, clip_w_i});
  assign hclip_e = $signed({{(EXT_BITS-CLIP_BITS){1'b0}}, clip_h_i});

  // Row range, end exclusive, shared by both shapes.
  assign top_raw = is_circle ? (py_e - r_e) : py_e;
  assign bot_raw = is_circle ? (py_e + r_e + ONE_E) : (py_e + h_e);
  assign ylo     = (top_raw < ZERO_E) ? ZERO_E : top_raw;
  assign bot_min = (bot_raw > hclip_e) ? hclip_e : bot_raw;
  assign yhi     = (bot_min < ZERO_E) ? ZERO_E : bot_min;
  assign yhi_d   = yhi[CLIP_BITS-1:0];

  // Rectangle columns are the same on every row.
  assign rect_r  = px_e + w_e;
  assign xl_d    = (px_e < ZERO_E) ? ZERO_E : px_e;
  assign xr_d    = ((rect_r > wclip_e) ? wclip_e : rect_r) - ONE_E;
  assign rsq_d   = SQ_BITS'(r_sat) * SQ_BITS'(r_sat);

  // Circle: half-width from r*r - dy*dy. |dy| stays within the radius.
  assign row_e  = $signed({{(EXT_BITS-ROW_BITS){1'b0}}, row_q});
  assign dy     = row_e - py_e;
  assign ady    = (dy < ZERO_E) ? -dy : dy;
  assign ady_n  = ady[RADIUS_BITS-1:0];
  assign rem_sq = rsq_q - SQ_BITS'(ady_n) * SQ_BITS'(ady_n);

  csr_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.root_start),
    .operand_i (rem_sq),
    .root_o    (root),
    .done_o    (root_done)
  );

  assign dx_e   = $signed({{(EXT_BITS-RADIUS_BITS){1'b0}}, root});
  assign cxl    = px_e - dx_e;
  assign cxr    = px_e + dx_e;
  assign cxl_c  = (cxl < ZERO_E) ? ZERO_E : cxl;
  assign cxr_c  = (cxr >= wclip_e) ? (wclip_e - ONE_E) : cxr;
  assign span_l = is_circle ? cxl_c : xl_q;
  assign span_r = is_circle ? cxr_c : xr_q;
  assign span_empty = (span_r < span_l);

  assign row_d = cmd_i.setup ? ylo[ROW_BITS-1:0] : (row_q + ROW_BITS'(1));

  assign status_o.is_circle = is_circle;
  assign status_o.no_rows   = (row_q >= ROW_BITS'(yhi_q));
  assign status_o.last_row  = ((ROW_BITS+1)'(row_q) + (ROW_BITS+1)'(1)) >= (ROW_BITS+1)'(yhi_q);
  assign status_o.out_free  = out_free;
  assign status_o.root_done = root_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= in_func_i;
      px_q    <= in_data_i[PY_LSB-1:0];
      py_q    <= in_data_i[W_LSB-1:PY_LSB];
      w_q     <= in_data_i[H_LSB-1:W_LSB];
      h_q     <= in_data_i[R_LSB-1:H_LSB];
      r_q     <= in_data_i[C_LSB-1:R_LSB];
      color_q <= in_data_i[IN_DATA_BITS-1:C_LSB];
    end
    if (cmd_i.setup) begin
      yhi_q <= yhi_d;
      xl_q  <= xl_d;
      xr_q  <= xr_d;
      rsq_q <= rsq_d;
    end
    if (cmd_i.emit_span) begin
      out_row_q   <= row_q[SPAN_BITS-1:0];
      out_start_q <= span_empty ? '0 : span_l[SPAN_BITS-1:0];
      out_end_q   <= span_empty ? '0 : span_r[SPAN_BITS-1:0];
      out_pix_q   <= {1'b1, color_q};
      out_empty_q <= span_empty;
      out_last_q  <= status_o.last_row;
    end else if (cmd_i.emit_none) begin
      out_row_q   <= '0;
      out_start_q <= '0;
      out_end_q   <= '0;
      out_pix_q   <= {1'b1, color_q};
      out_empty_q <= 1'b1;
      out_last_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.setup || cmd_i.emit_span) begin
        row_q <= row_d;
      end
      if (cmd_i.emit_span || cmd_i.emit_none) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_pix_q, out_end_q, out_start_q, out_row_q};
  assign out_empty_o = out_empty_q;
  assign out_last_o  = out_last_q;

  // A non-empty span never runs backwards.
  a_span_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_empty_q |-> out_start_q <= out_end_q)
    else $error("span start beyond span end");

  // An empty result carries zero columns.
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_empty_q |-> out_start_q == '0 && out_end_q == '0)
    else $error("empty result with nonzero columns");

  // Never overwrite a result that has not been taken.
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_span || cmd_i.emit_none |-> out_free)
    else $error("output register overrun");

endmodule

// ===== hdl/csr_ctrl.sv =====
// Controller state machine: sequences setup, square roots and span emission.
// Depends on csr_pkg.
module csr_ctrl import csr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  csr_status_t status_i,
  output csr_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_FIRST,
    ST_DIST,
    ST_ROOT,
    ST_SPAN,
    ST_NONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_FIRST;
      end
      ST_FIRST: begin
        if (status_i.no_rows) begin
          state_d = ST_NONE;
        end else if (status_i.is_circle) begin
          state_d = ST_DIST;
        end else begin
          state_d = ST_SPAN;
        end
      end
      ST_DIST: begin
        cmd_o.root_start = 1'b1;
        state_d          = ST_ROOT;
      end
      ST_ROOT: begin
        if (status_i.root_done) begin
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        if (status_i.out_free) begin
          cmd_o.emit_span = 1'b1;
          if (status_i.last_row) begin
            state_d = ST_IDLE;
          end else if (status_i.is_circle) begin
            state_d = ST_DIST;
          end
        end
      end
      ST_NONE: begin
        if (status_i.out_free) begin
          cmd_o.emit_none = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/clipped_shape_span_rasterizer_unit.sv =====
// Top level of the clipped shape span rasterizer: clip registers and wiring.
// Depends on csr_pkg, csr_ctrl and csr_dp (which holds csr_isqrt).
//
// Usage:
//   s_axis_* takes one draw command per transaction: a filled rectangle or a
//   filled circle (kind on s_axis_tuser). m_axis_* returns one span per
//   covered screen row, top row first; m_axis_tlast marks the final span of
//   the command and m_axis_tuser flags a row whose clipped span is empty. A
//   command that covers no row returns a single empty span at row 0.
//   cfg_we_i writes clip_width (index 0) or clip_height (index 1); write only
//   while no command is in flight. Zero acts as 1, values above 256 as 256.
// Timing:
//   An accepted command passes setup and a first-row check before its first span;
//   rectangles then give one span per cycle while the output register is free.
//   Circles run a bit-serial square root per row before each span.
//   A new command is taken once the last span of the previous one sits in
//   the output register, even if that span is still waiting.
// Reset:
//   Clip registers return to 256 x 192; the controller returns to idle and
//   the output register empties.
// Stall:
//   While m_axis_tready is low the pending span holds and row walking stops once the output register is full.
module clipped_shape_span_rasterizer_unit import csr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CLIP_BITS-1:0]     cfg_data_i,
  // Command stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [9:0] pos_x, [19:10] pos_y, [28:20] rect_width, [35:29] rect_height,
  // [40:36] radius, [55:41] color
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // [0] func
  input  logic [0:0]               s_axis_tuser,
  // Span stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [7:0] row, [15:8] span_start, [23:16] span_end, [39:24] pixel_value
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  // [0] span_empty
  output logic [0:0]               m_axis_tuser,
  output logic                     m_axis_tlast
);

  localparam logic [CLIP_BITS-1:0] CLIP_W_RESET = CLIP_BITS'(256);
  localparam logic [CLIP_BITS-1:0] CLIP_H_RESET = CLIP_BITS'(192);

  logic [CLIP_BITS-1:0] clip_w_q, clip_h_q;
  logic [CLIP_BITS-1:0] clip_w_eff, clip_h_eff;
  csr_cmd_t             cmd;
  csr_status_t          status;

  // Fold out-of-range clip values into 1..256.
  function automatic logic [CLIP_BITS-1:0] clip_lim(input logic [CLIP_BITS-1:0] v);
    logic [CLIP_BITS-1:0] res;
    if (v == '0) begin
      res = CLIP_BITS'(1);
    end else if (v > CLIP_BITS'(SCREEN_MAX)) begin
      res = CLIP_BITS'(SCREEN_MAX);
    end else begin
      res = v;
    end
    return res;
  endfunction

  assign clip_w_eff = clip_lim(clip_w_q);
  assign clip_h_eff = clip_lim(clip_h_q);

  // Clip registers: write-only, taken on any cycle with the enable high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_w_q <= CLIP_W_RESET;
      clip_h_q <= CLIP_H_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CLIP_WIDTH:  clip_w_q <= cfg_data_i;
        REG_CLIP_HEIGHT: clip_h_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  csr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  csr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .clip_w_i    (clip_w_eff),
    .clip_h_i    (clip_h_eff),
    .in_data_i   (s_axis_tdata),
    .in_func_i   (s_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_empty_o (m_axis_tuser[0]),
    .out_last_o  (m_axis_tlast)
  );

endmodule
